FILE: rtl/btpc_pkg.sv
// btpc_pkg: shared types and constants of the barometric compensation core
// payload structs, calibration coefficient struct, register indexes
// no dependencies
package btpc_pkg;

	typedef struct packed {
		logic [15:0] raw_temperature;
		logic [23:0] raw_pressure_bytes;
	} btpc_in_t;

	typedef struct packed {
		logic signed [15:0] temperature_tenths;
		logic [19:0]        pressure_pascal;
		logic               divide_fault;
	} btpc_out_t;

	// calibration coefficients as decoded from the configuration registers
	typedef struct packed {
		logic signed [15:0] ac1;
		logic signed [15:0] ac2;
		logic signed [15:0] ac3;
		logic [15:0]        ac4;
		logic [15:0]        ac5;
		logic [15:0]        ac6;
		logic signed [15:0] b1;
		logic signed [15:0] b2;
		logic signed [15:0] mc;
		logic signed [15:0] md;
		logic [1:0]         oss;
	} btpc_coef_t;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B1_B2   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OSS     = 3'd5;

	localparam logic signed [28:0] T_ROUND   = 29'sd8;
	localparam logic signed [28:0] B6_OFFSET = 29'sd4000;
	localparam logic signed [41:0] B4_BIAS   = 42'sd32768;
	localparam logic [15:0]        B7_SCALE  = 16'd50000;
	localparam logic signed [12:0] C_SQ      = 13'sd3038;
	localparam logic signed [14:0] C_LIN     = -15'sd7357;
	localparam logic signed [12:0] C_OFS     = 13'sd3791;
	localparam logic signed [42:0] P_MAX     = 43'sd1048575;

endpackage

FILE: rtl/barometric_temp_pressure_compensation_core.sv
// barometric_temp_pressure_compensation_core: integer compensation of raw
// temperature and pressure readings; uses btpc_pkg, btpc_div and btpc_coef
//
// Usage: load the five calibration words and the oversampling mode through
// cfg_we / cfg_index / cfg_wdata while no item is in flight; a write takes
// effect at the clock edge where cfg_we is high. Samples enter on in_valid /
// in_ready as btpc_in_t and leave on out_valid / out_ready as btpc_out_t,
// one result per sample, in order.
// Throughput is one sample per cycle while in_ready is high; most of the
// depth comes from the two bit-per-stage dividers (27 stages for the
// temperature divide, 64 for the pressure divide).
// Reset clears all calibration registers and every stage valid bit.
// When the receiver stalls, the result holds in the output register; the
// pipeline keeps moving until its last stage holds a result too, and only
// then does in_ready drop and the whole pipeline freeze.
module barometric_temp_pressure_compensation_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  btpc_pkg::btpc_in_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output btpc_pkg::btpc_out_t                 out_data,
	input  logic                                cfg_we,
	input  logic [btpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [btpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import btpc_pkg::*;

	// configuration
	logic [31:0] cal_ac1_ac2_q, cal_ac3_ac4_q, cal_ac5_ac6_q, cal_b1_b2_q, cal_mc_md_q;
	logic [1:0]  oss_q;
	btpc_coef_t  coef;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_ac1_ac2_q <= '0;
			cal_ac3_ac4_q <= '0;
			cal_ac5_ac6_q <= '0;
			cal_b1_b2_q   <= '0;
			cal_mc_md_q   <= '0;
			oss_q         <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AC1_AC2: cal_ac1_ac2_q <= cfg_wdata;
				REG_AC3_AC4: cal_ac3_ac4_q <= cfg_wdata;
				REG_AC5_AC6: cal_ac5_ac6_q <= cfg_wdata;
				REG_B1_B2:   cal_b1_b2_q   <= cfg_wdata;
				REG_MC_MD:   cal_mc_md_q   <= cfg_wdata;
				REG_OSS:     oss_q         <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	assign coef.ac1 = cal_ac1_ac2_q[31:16];
	assign coef.ac2 = cal_ac1_ac2_q[15:0];
	assign coef.ac3 = cal_ac3_ac4_q[31:16];
	assign coef.ac4 = cal_ac3_ac4_q[15:0];
	assign coef.ac5 = cal_ac5_ac6_q[31:16];
	assign coef.ac6 = cal_ac5_ac6_q[15:0];
	assign coef.b1  = cal_b1_b2_q[31:16];
	assign coef.b2  = cal_b1_b2_q[15:0];
	assign coef.mc  = cal_mc_md_q[31:16];
	assign coef.md  = cal_mc_md_q[15:0];
	assign coef.oss = oss_q;

	// pipeline advance: freeze only when the last stage and the output register are both full
	logic adv;
	logic v_s7;
	logic out_valid_q;
	btpc_out_t out_q;

	assign adv      = !v_s7 || !out_valid_q || out_ready;
	assign in_ready = adv;

	// stage 1: (UT - ac6) * ac5 and shifted UP
	logic signed [16:0] ut_x, ac6_x, ac5_x, ut_d;
	logic [3:0]         up_sh;
	logic               v_s1;
	logic signed [33:0] prod_s1;
	logic [23:0]        up_s1;

	assign ut_x  = {1'b0, in_data.raw_temperature};
	assign ac6_x = {1'b0, coef.ac6};
	assign ac5_x = {1'b0, coef.ac5};
	assign ut_d  = ut_x - ac6_x;
	assign up_sh = 4'd8 - {2'b00, coef.oss};

	// temperature divider operands
	logic signed [18:0] x1_t;
	logic signed [19:0] den_t;
	logic signed [26:0] mcx;
	logic [26:0]        tnum_mag;
	logic [19:0]        tden_mag;
	logic               t_neg, t_zero;
	localparam int TSW = 19 + 24 + 2;
	logic [TSW-1:0]     tside;

	assign x1_t     = prod_s1[33:15];
	assign den_t    = 20'(x1_t) + 20'(coef.md);
	assign mcx      = {coef.mc, 11'b0};
	assign tnum_mag = mcx[26] ? 27'(-mcx) : mcx;
	assign tden_mag = den_t[19] ? 20'(-den_t) : den_t;
	assign t_neg    = mcx[26] ^ den_t[19];
	assign t_zero   = den_t == '0;
	assign tside    = {x1_t, up_s1, t_zero, t_neg};

	logic               tdv_valid;
	logic [26:0]        tq;
	logic [TSW-1:0]     tside_o;

	btpc_div #(.NW(27), .DW(20), .SW(TSW)) u_tdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s1),
		.num       (tnum_mag),
		.den       (tden_mag),
		.side      (tside),
		.out_valid (tdv_valid),
		.quo       (tq),
		.out_side  (tside_o)
	);

	// stage 2: B5, temperature and B6
	logic signed [18:0] x1_d;
	logic [23:0]        up_d;
	logic               zero_d, neg_d;
	logic signed [27:0] q1s, x2_t;
	logic signed [28:0] b5, t_full;
	logic               v_s2;
	logic signed [15:0] t_s2;
	logic               fault_s2;
	logic [23:0]        up_s2;
	logic signed [27:0] b6_s2;

	assign x1_d   = tside_o[TSW-1:26];
	assign up_d   = tside_o[25:2];
	assign zero_d = tside_o[1];
	assign neg_d  = tside_o[0];
	assign q1s    = {1'b0, tq};
	assign x2_t   = zero_d ? '0 : (neg_d ? -q1s : q1s);
	assign b5     = 29'(x1_d) + 29'(x2_t);
	assign t_full = (b5 + T_ROUND) >>> 4;

	// B3, B4, B7
	localparam int CSW = 17;
	logic               cv;
	logic signed [63:0] b7;
	logic signed [43:0] b4;
	logic [CSW-1:0]     cside;

	btpc_coef #(.SW(CSW)) u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.coef      (coef),
		.in_valid  (v_s2),
		.b6        (b6_s2),
		.up        (up_s2),
		.side      ({t_s2, fault_s2}),
		.out_valid (cv),
		.b7        (b7),
		.b4        (b4),
		.out_side  (cside)
	);

	// stage 3: pressure divider operands
	logic               b7_fits;
	logic signed [63:0] pnum;
	logic               v_s3;
	logic [63:0]        pnum_s3;
	logic [43:0]        pden_s3;
	localparam int PSW = 16 + 3;
	logic [PSW-1:0]     pside_s3;

	assign b7_fits = b7[63:31] == '0;
	assign pnum    = b7_fits ? {b7[62:0], 1'b0} : b7;

	logic               pdv_valid;
	logic [63:0]        pq;
	logic [PSW-1:0]     pside_o;

	btpc_div #(.NW(64), .DW(44), .SW(PSW)) u_pdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.num       (pnum_s3),
		.den       (pden_s3),
		.side      (pside_s3),
		.out_valid (pdv_valid),
		.quo       (pq),
		.out_side  (pside_o)
	);

	// stage 4: sign, doubling and saturation to 32 bits
	logic               pneg_d, post2_d;
	logic [64:0]        val65;
	logic signed [65:0] sv66, pv;
	logic               v_s4;
	logic signed [31:0] p_s4;
	logic signed [15:0] t_s4;
	logic               fault_s4;

	assign pneg_d  = pside_o[1];
	assign post2_d = pside_o[0];
	assign val65   = post2_d ? {pq, 1'b0} : {1'b0, pq};
	assign sv66    = {1'b0, val65};
	assign pv      = pneg_d ? -sv66 : sv66;

	// stage 5: correction products
	logic signed [23:0] ph;
	logic               v_s5;
	logic signed [47:0] psq_s5;
	logic signed [46:0] m2_s5;
	logic signed [31:0] p_s5;
	logic signed [15:0] t_s5;
	logic               fault_s5;

	assign ph = p_s4[31:8];

	// stage 6: scaled correction terms
	logic signed [60:0] xa_full;
	logic               v_s6;
	logic signed [44:0] xa_s6;
	logic signed [30:0] xb_s6;
	logic signed [31:0] p_s6;
	logic signed [15:0] t_s6;
	logic               fault_s6;

	assign xa_full = 61'(psq_s5) * 61'(C_SQ);

	// stage 7: final sum and clamp
	logic signed [45:0] csum;
	logic signed [42:0] pf;
	logic [19:0]        pres;
	btpc_out_t          res_s7;

	assign csum = 46'(xa_s6) + 46'(xb_s6) + 46'(C_OFS);
	assign pf   = 43'(p_s6) + 43'(csum >>> 4);

	always_comb begin
		if (fault_s6 || pf < 0) begin
			pres = '0;
		end else if (pf > P_MAX) begin
			pres = P_MAX[19:0];
		end else begin
			pres = pf[19:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= tdv_valid;
			v_s3 <= cv;
			v_s4 <= pdv_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= ut_d * ac5_x;
			up_s1   <= in_data.raw_pressure_bytes >> up_sh;

			if (t_full > 29'sd32767) begin
				t_s2 <= 16'sh7fff;
			end else if (t_full < -29'sd32768) begin
				t_s2 <= 16'sh8000;
			end else begin
				t_s2 <= t_full[15:0];
			end
			fault_s2 <= zero_d;
			up_s2    <= up_d;
			b6_s2    <= 28'(b5 - B6_OFFSET);

			pnum_s3  <= pnum[63] ? 64'(-pnum) : pnum;
			pden_s3  <= b4[43] ? 44'(-b4) : b4;
			pside_s3 <= {cside[CSW-1:1], cside[0] | (b4 == '0), pnum[63] ^ b4[43], !b7_fits};

			if (pv > 66'sd2147483647) begin
				p_s4 <= 32'sh7fffffff;
			end else if (pv < -66'sd2147483648) begin
				p_s4 <= 32'sh80000000;
			end else begin
				p_s4 <= pv[31:0];
			end
			t_s4     <= pside_o[PSW-1:3];
			fault_s4 <= pside_o[2];

			psq_s5   <= ph * ph;
			m2_s5    <= 47'(p_s4) * 47'(C_LIN);
			p_s5     <= p_s4;
			t_s5     <= t_s4;
			fault_s5 <= fault_s4;

			xa_s6    <= 45'(xa_full >>> 16);
			xb_s6    <= 31'(m2_s5 >>> 16);
			p_s6     <= p_s5;
			t_s6     <= t_s5;
			fault_s6 <= fault_s5;

			res_s7.temperature_tenths <= t_s6;
			res_s7.pressure_pascal    <= pres;
			res_s7.divide_fault       <= fault_s6;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			out_valid_q <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_q <= res_s7;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// a faulted result never carries a pressure
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_fault |-> out_data.pressure_pascal == '0)
		else $error("divide fault with nonzero pressure");

	// input side only stalls when the output is blocked and the last stage is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready && v_s7)
		else $error("pipeline stalled without a blocked output");

	// oversampling register picks up the written value
	a_oss_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == REG_OSS |=> oss_q == $past(cfg_wdata[1:0]))
		else $error("oversampling mode write lost");

endmodule

FILE: rtl/btpc_div.sv
// btpc_div: pipelined restoring divider on magnitudes, one quotient bit per stage
// carries a sideband word alongside each division; depends on nothing
module btpc_div #(
	parameter int NW = 64,
	parameter int DW = 44,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] out_side
);

	logic          v_s    [NW];
	logic [DW-1:0] rem_s  [NW];
	logic [NW-1:0] nq_s   [NW];
	logic [DW-1:0] den_s  [NW];
	logic [SW-1:0] side_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic          v_i;
		logic [DW-1:0] rem_i;
		logic [NW-1:0] nq_i;
		logic [DW-1:0] den_i;
		logic [SW-1:0] side_i;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_i    = in_valid;
			assign rem_i  = '0;
			assign nq_i   = num;
			assign den_i  = den;
			assign side_i = side;
		end else begin : g_next
			assign v_i    = v_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign nq_i   = nq_s[k-1];
			assign den_i  = den_s[k-1];
			assign side_i = side_s[k-1];
		end

		// shift in the next dividend bit and try the subtraction
		assign trial = {rem_i, nq_i[NW-1]};
		assign ge    = trial >= {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
				nq_s[k]   <= {nq_i[NW-2:0], ge};
				den_s[k]  <= den_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = v_s[NW-1];
	assign quo       = nq_s[NW-1];
	assign out_side  = side_s[NW-1];

endmodule

FILE: rtl/btpc_coef.sv
// btpc_coef: six-stage multiply pipeline forming B7 and B4 from B6 and raw pressure
// uses btpc_pkg for the coefficient struct and constants
module btpc_coef #(
	parameter int SW = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  btpc_pkg::btpc_coef_t  coef,
	input  logic                  in_valid,
	input  logic signed [27:0]    b6,
	input  logic [23:0]           up,
	input  logic [SW-1:0]         side,
	output logic                  out_valid,
	output logic signed [63:0]    b7,
	output logic signed [43:0]    b4,
	output logic [SW-1:0]         out_side
);
	import btpc_pkg::*;

	logic v_c1, v_c2, v_c3, v_c4, v_c5, v_c6;

	// stage 1: squares and first products of B6
	logic signed [55:0] b6sq;
	logic [41:0]        sq_c1;
	logic signed [43:0] ac2b6_c1, ac3b6_c1;
	logic [23:0]        up_c1;
	logic [SW-1:0]      side_c1;

	assign b6sq = b6 * b6;

	// stage 2: sq times b1, b2
	logic signed [42:0] sqs;
	logic signed [58:0] b2sq_c2, b1sq_c2;
	logic signed [43:0] ac2b6_c2, ac3b6_c2;
	logic [23:0]        up_c2;
	logic [SW-1:0]      side_c2;

	assign sqs = {1'b0, sq_c1};

	// stage 3: the two X3 sums
	logic signed [47:0] x3a_c3;
	logic signed [43:0] x3b_sum;
	logic signed [40:0] x3b_c3;
	logic [23:0]        up_c3;
	logic [SW-1:0]      side_c3;

	assign x3b_sum = 44'(ac3b6_c2 >>> 13) + 44'(b1sq_c2 >>> 16) + 44'sd2;

	// stage 4: B3 with truncating divide by four
	logic signed [52:0] v_sum, v_sh, v2;
	logic signed [50:0] b3_c4;
	logic signed [41:0] y_c4;
	logic [23:0]        up_c4;
	logic [SW-1:0]      side_c4;

	assign v_sum = (53'(coef.ac1) <<< 2) + 53'(x3a_c3);
	assign v_sh  = v_sum <<< coef.oss;
	assign v2    = v_sh + 53'sd2;

	// stage 5: UP - B3 and the B4 product
	logic signed [24:0] ups;
	logic signed [16:0] ac4s;
	logic signed [51:0] diff_c5;
	logic signed [58:0] b4p_c5;
	logic [SW-1:0]      side_c5;

	assign ups  = {1'b0, up_c4};
	assign ac4s = {1'b0, coef.ac4};

	// stage 6: B7 and B4
	logic signed [16:0] scale;
	logic signed [68:0] b7full;

	assign scale  = {1'b0, B7_SCALE >> coef.oss};
	assign b7full = 69'(diff_c5) * 69'(scale);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c1 <= 1'b0;
			v_c2 <= 1'b0;
			v_c3 <= 1'b0;
			v_c4 <= 1'b0;
			v_c5 <= 1'b0;
			v_c6 <= 1'b0;
		end else if (en) begin
			v_c1 <= in_valid;
			v_c2 <= v_c1;
			v_c3 <= v_c2;
			v_c4 <= v_c3;
			v_c5 <= v_c4;
			v_c6 <= v_c5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_c1    <= b6sq[53:12];
			ac2b6_c1 <= coef.ac2 * b6;
			ac3b6_c1 <= coef.ac3 * b6;
			up_c1    <= up;
			side_c1  <= side;

			b2sq_c2  <= coef.b2 * sqs;
			b1sq_c2  <= coef.b1 * sqs;
			ac2b6_c2 <= ac2b6_c1;
			ac3b6_c2 <= ac3b6_c1;
			up_c2    <= up_c1;
			side_c2  <= side_c1;

			x3a_c3   <= 48'(b2sq_c2 >>> 11) + 48'(ac2b6_c2 >>> 11);
			x3b_c3   <= 41'(x3b_sum >>> 2);
			up_c3    <= up_c2;
			side_c3  <= side_c2;

			b3_c4    <= v2[52] ? 51'((v2 + 53'sd3) >>> 2) : 51'(v2 >>> 2);
			y_c4     <= 42'(x3b_c3) + B4_BIAS;
			up_c4    <= up_c3;
			side_c4  <= side_c3;

			diff_c5  <= 52'(ups) - 52'(b3_c4);
			b4p_c5   <= 59'(y_c4) * 59'(ac4s);
			side_c5  <= side_c4;

			b7       <= b7full[63:0];
			b4       <= 44'(b4p_c5 >>> 15);
			out_side <= side_c5;
		end
	end

	assign out_valid = v_c6;

endmodule

FILE: sim/tb.sv
// tb: self-checking testbench of barometric_temp_pressure_compensation_core
// predicts every sample from its own copy of the calibration, checks results in order
// depends on rtl/btpc_pkg.sv and the core rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import btpc_pkg::*;

	localparam int LATENCY = 104;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD = 500;
	localparam longint T_OFS = 4000;
	localparam longint PSCALE = 50000;
	localparam longint K_SQ = 3038;
	localparam longint K_LIN = -7357;
	localparam longint K_OFS = 3791;
	localparam longint PCLAMP = 1048575;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	btpc_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	btpc_out_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	logic [31:0] cal [0:5];
	btpc_out_t expected_q [$];
	int mismatches = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int faults_seen = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	barometric_temp_pressure_compensation_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic btpc_out_t compensate(btpc_in_t s);
		longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		longint ut, up, x1, x2, x3, den, b5, b6, b3, b4, b7, sq, p, t;
		int oss;
		bit fault;
		btpc_out_t r;
		ac1 = longint'($signed(cal[REG_AC1_AC2][31:16]));
		ac2 = longint'($signed(cal[REG_AC1_AC2][15:0]));
		ac3 = longint'($signed(cal[REG_AC3_AC4][31:16]));
		ac4 = longint'(cal[REG_AC3_AC4][15:0]);
		ac5 = longint'(cal[REG_AC5_AC6][31:16]);
		ac6 = longint'(cal[REG_AC5_AC6][15:0]);
		b1 = longint'($signed(cal[REG_B1_B2][31:16]));
		b2 = longint'($signed(cal[REG_B1_B2][15:0]));
		mc = longint'($signed(cal[REG_MC_MD][31:16]));
		md = longint'($signed(cal[REG_MC_MD][15:0]));
		oss = int'(cal[REG_OSS][1:0]);
		ut = longint'(s.raw_temperature);
		up = longint'(s.raw_pressure_bytes >> (8 - oss));
		fault = 1'b0;

		x1 = ((ut - ac6) * ac5) >>> 15;
		den = x1 + md;
		if (den == 0) begin
			x2 = 0;
			fault = 1'b1;
		end else begin
			x2 = (mc * 2048) / den;
		end
		b5 = x1 + x2;
		t = (b5 + 8) >>> 4;
		if (t > 32767) t = 32767;
		if (t < -32768) t = -32768;

		b6 = b5 - T_OFS;
		sq = (b6 * b6) >>> 12;
		x1 = (b2 * sq) >>> 11;
		x2 = (ac2 * b6) >>> 11;
		x3 = x1 + x2;
		b3 = ((ac1 * 4 + x3) * (longint'(1) << oss) + 2) / 4;
		x1 = (ac3 * b6) >>> 13;
		x2 = (b1 * sq) >>> 16;
		x3 = (x1 + x2 + 2) >>> 2;
		b4 = (ac4 * (x3 + 32768)) >>> 15;
		b7 = (up - b3) * (PSCALE >>> oss);

		p = 0;
		if (b4 == 0) fault = 1'b1;
		if (!fault) begin
			// small positive b7 keeps the extra bit, the rest divides first
			if (b7 >= 0 && b7 < 64'sd2147483648) p = (b7 * 2) / b4;
			else p = (b7 / b4) * 2;
			if (p > 64'sd2147483647) p = 64'sd2147483647;
			if (p < -64'sd2147483648) p = -64'sd2147483648;
			x1 = (p >>> 8) * (p >>> 8);
			x1 = (x1 * K_SQ) >>> 16;
			x2 = (K_LIN * p) >>> 16;
			p = p + ((x1 + x2 + K_OFS) >>> 4);
			if (p < 0) p = 0;
			if (p > PCLAMP) p = PCLAMP;
		end
		r.temperature_tenths = t[15:0];
		r.pressure_pascal = p[19:0];
		r.divide_fault = fault;
		return r;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		mismatches++;
		$display("mismatch at result %0d: %s got %0d expected %0d",
			results_seen, field, got, want);
	endtask

	// input transfers feed the prediction store
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_q.push_back(compensate(in_data));
			samples_sent++;
		end
	end

	always @(posedge clk) begin
		btpc_out_t want;
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = expected_q.pop_front();
				if (out_data.temperature_tenths !== want.temperature_tenths)
					report_mismatch("temperature_tenths", out_data.temperature_tenths,
						want.temperature_tenths);
				if (out_data.pressure_pascal !== want.pressure_pascal)
					report_mismatch("pressure_pascal", out_data.pressure_pascal,
						want.pressure_pascal);
				if (out_data.divide_fault !== want.divide_fault)
					report_mismatch("divide_fault", out_data.divide_fault, want.divide_fault);
				if (want.divide_fault) faults_seen++;
			end
			results_seen++;
		end
	end

	// receiver: random hold-off before each transfer unless calm, one long hold on request
	initial begin
		int g;
		forever begin
			if (hold_req) g = LONG_HOLD;
			else if (calm) g = 0;
			else g = $urandom_range(0, 13);
			if (g > 0) begin
				out_ready <= 1'b0;
				repeat (g) @(posedge clk);
				hold_req = 1'b0;
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic send_sample(logic [15:0] ut, logic [23:0] praw);
		int g;
		g = calm ? 0 : $urandom_range(0, 13);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{raw_temperature: ut, raw_pressure_bytes: praw};
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx < REG_OSS) cal[idx] = val;
		else if (idx == REG_OSS) cal[idx] = {30'd0, val[1:0]};
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 6) @(posedge clk);
	endtask

	task automatic load_cal(logic [31:0] w0, w1, w2, w3, w4, logic [1:0] oss);
		write_reg(REG_AC1_AC2, w0);
		write_reg(REG_AC3_AC4, w1);
		write_reg(REG_AC5_AC6, w2);
		write_reg(REG_B1_B2, w3);
		write_reg(REG_MC_MD, w4);
		write_reg(REG_OSS, {30'd0, oss});
	endtask

	// typical factory calibration, used as the base of well-formed phases
	task automatic load_typical(logic [1:0] oss);
		load_cal({16'sd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
			{16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868}, oss);
	endtask

	task automatic test_reset_values();
		// all-zero calibration: temperature divisor is zero
		send_sample(16'd0, 24'd0);
		send_sample(16'hffff, 24'hffffff);
		send_sample(16'd27898, 24'h5d2300);
		drain();
	endtask

	task automatic test_typical_extremes();
		for (int m = 0; m < 4; m++) begin
			load_typical(m[1:0]);
			send_sample(16'd27898, 24'd23843 << (8 - m));
			send_sample(16'd0, 24'd0);
			send_sample(16'hffff, 24'hffffff);
			send_sample(16'd0, 24'hffffff);
			drain();
		end
	endtask

	task automatic test_special_cases();
		// ut equal to ac6 with md zero gives a zero temperature divisor
		load_cal({16'sd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
			{16'sd6190, 16'sd4}, {-16'sd8711, 16'sd0}, 2'd1);
		send_sample(16'd23153, 24'h800000);
		send_sample(16'd23154, 24'h800000);
		drain();
		// ac4 zero gives a zero pressure divisor
		load_cal({16'sd408, -16'sd72}, {-16'sd14383, 16'd0}, {16'd32757, 16'd23153},
			{16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868}, 2'd0);
		send_sample(16'd27898, 24'h5d2300);
		drain();
		// extreme coefficients: saturated temperature, clamped pressure both ways
		load_cal(32'h7fff8000, 32'h8000ffff, 32'hffffffff, 32'h7fff7fff, 32'h7fff0001, 2'd3);
		send_sample(16'hffff, 24'hffffff);
		send_sample(16'd0, 24'd0);
		drain();
		load_cal(32'h80007fff, 32'h7fff0001, 32'hffff0000, 32'h80008000, 32'h80000001, 2'd2);
		send_sample(16'hffff, 24'd0);
		send_sample(16'd1, 24'hffffff);
		// writes to indexes beyond the list are ignored
		drain();
		write_reg(3'd6, 32'hffffffff);
		write_reg(3'd7, 32'h12345678);
		send_sample(16'd12345, 24'h123456);
		drain();
	endtask

	task automatic random_phase(int n, bit typical);
		int dt, dp;
		logic [1:0] oss;
		oss = 2'($urandom_range(0, 3));
		if (typical) begin
			load_cal({16'(408 + $urandom_range(0, 400) - 200), 16'(-72 + $urandom_range(0, 40))},
				{16'(-14383 + $urandom_range(0, 2000)), 16'(32741 - $urandom_range(0, 3000))},
				{16'(32757 - $urandom_range(0, 3000)), 16'(23153 + $urandom_range(0, 2000))},
				{16'(6190 + $urandom_range(0, 200)), 16'($urandom_range(0, 8))},
				{16'(-8711 + $urandom_range(0, 500)), 16'(2868 + $urandom_range(0, 200))}, oss);
		end else begin
			load_cal($urandom, $urandom, $urandom, $urandom, $urandom, oss);
		end
		for (int i = 0; i < n; i++) begin
			if (typical && $urandom_range(0, 9) != 0) begin
				dt = $urandom_range(0, 8000);
				dp = $urandom_range(0, 20000);
				send_sample(16'(23898 + dt), 24'((20000 + dp) << (8 - oss)));
			end else begin
				send_sample(16'($urandom), 24'($urandom));
			end
		end
		drain();
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 8; ph++) begin
			calm = (ph == 3);
			random_phase(110, ph % 3 != 2);
		end
		calm = 1'b0;
	endtask

	task automatic test_backpressure();
		// receiver holds off long enough to fill the pipeline and stall the input
		hold_req = 1'b1;
		calm = 1'b1;
		random_phase(150, 1'b1);
		calm = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < 6; i++) cal[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_typical_extremes();
		test_special_cases();
		test_random();
		test_backpressure();
		drain();
		$display("covered %0d samples over directed, random and stalled phases", samples_sent);
		$display("%0d results checked, %0d with a divide fault, %0d mismatches",
			results_seen, faults_seen, mismatches);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule

FILE: filelist.f
rtl/btpc_pkg.sv
rtl/btpc_div.sv
rtl/btpc_coef.sv
rtl/barometric_temp_pressure_compensation_core.sv
sim/tb.sv
